// ===== rtl/asd_pkg.sv =====
// ----------------------------------------------------------------------------
// asd_pkg
// Shared types, sizes and codes of the additive seasonal decomposition block.
// ----------------------------------------------------------------------------
package asd_pkg;

  localparam int MAX_SAMPLES = 1024;
  localparam int MAX_PERIOD  = 64;
  localparam int SAW        = $clog2(MAX_SAMPLES);     // sample address width
  localparam int CNTW       = $clog2(MAX_SAMPLES) + 1; // sample count width
  localparam int PAW        = $clog2(MAX_PERIOD);      // phase address width
  localparam int PSUMW      = 48;                      // phase sum width
  localparam int DIVW       = 49;                      // divider numerator width
  localparam int DIVDW      = CNTW;                    // divider denominator width
  localparam int DIV_STEPS  = DIVW;
  localparam int DIVCW      = $clog2(DIV_STEPS + 1);

  localparam logic [1:0] OP_PUSH     = 2'd0;
  localparam logic [1:0] OP_FINALIZE = 2'd1;
  localparam logic [1:0] OP_READ     = 2'd2;
  localparam logic [1:0] OP_UNUSED   = 2'd3;

  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_RANGE    = 2'd1;
  localparam logic [1:0] STAT_NOT_FIN  = 2'd2;
  localparam logic [1:0] STAT_OK_DROP  = 2'd3;

  localparam logic [1:0] REG_WINDOW = 2'd0;
  localparam logic [1:0] REG_PERIOD = 2'd1;

  typedef struct packed {
    logic [1:0]         operation;
    logic signed [31:0] sample;
    logic [9:0]         position;
  } asd_req_t;

  typedef struct packed {
    logic signed [31:0] trend;
    logic signed [31:0] season;
    logic signed [31:0] rest;
    logic [1:0]         status;
  } asd_res_t;

  typedef struct packed {
    logic              go;
    logic [DIVW-1:0]   num;
    logic [DIVDW-1:0]  den;
  } asd_div_req_t;

  typedef struct packed {
    logic              done;
    logic [DIVW-1:0]   quo;
    logic [DIVDW-1:0]  rem;
  } asd_div_rsp_t;

  function automatic logic signed [31:0] sat32(input logic signed [50:0] v);
    logic signed [31:0] r;
    if (v > 51'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -51'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

// ===== rtl/additive_seasonal_decomposition_top.sv =====
// ----------------------------------------------------------------------------
// additive_seasonal_decomposition_top
// Classical additive decomposition of a Q15.16 series held in block RAM.
//
//   channel   signals                            handshake
//   request   start, busy, request               taken when start & !busy
//   result    strobe, result                     one cycle, no back pressure
//   config    cfg_valid, cfg_ready, cfg_index,   taken when valid & ready
//             cfg_data
//
// push: stores the sample; once a window is full, sums it and runs the trend divide.
// finalize: with a full window stored, copies the edge trends, then adds each sample to its phase.
// read: phase modulo, then seasonal divide, both in the shared divider; a refused
// read answers in the next cycle.
// reset and register writes clear counters and flags; memories need no sweep.
// ----------------------------------------------------------------------------
module additive_seasonal_decomposition_top
  import asd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  asd_req_t   request,
  output logic       strobe,
  output asd_res_t   result,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [6:0] cfg_data
);

  localparam logic [4:0] ST_IDLE  = 5'd0;
  localparam logic [4:0] ST_WRD   = 5'd1;
  localparam logic [4:0] ST_WACC  = 5'd2;
  localparam logic [4:0] ST_WDIV  = 5'd3;
  localparam logic [4:0] ST_WWAIT = 5'd4;
  localparam logic [4:0] ST_FRD1  = 5'd5;
  localparam logic [4:0] ST_FCAP1 = 5'd6;
  localparam logic [4:0] ST_FLEAD = 5'd7;
  localparam logic [4:0] ST_FRD2  = 5'd8;
  localparam logic [4:0] ST_FCAP2 = 5'd9;
  localparam logic [4:0] ST_FTAIL = 5'd10;
  localparam logic [4:0] ST_PRD   = 5'd11;
  localparam logic [4:0] ST_PACC  = 5'd12;
  localparam logic [4:0] ST_RMOD  = 5'd13;
  localparam logic [4:0] ST_RRD   = 5'd14;
  localparam logic [4:0] ST_RCAP  = 5'd15;
  localparam logic [4:0] ST_RDIV  = 5'd16;
  localparam logic [4:0] ST_ROUT  = 5'd17;

  logic [4:0]              state;
  logic [5:0]              window_length;
  logic [6:0]              season_period;
  logic [CNTW-1:0]         count;
  logic                    finalized;
  logic                    overflowed;
  logic [CNTW-1:0]         idx;
  logic [CNTW-1:0]         first;
  logic [CNTW-1:0]         last;
  logic signed [39:0]      acc;
  logic                    neg;
  logic signed [31:0]      edge_val;
  logic [PAW-1:0]          ph;
  logic [SAW-1:0]          pos;
  logic signed [31:0]      s_val;
  logic signed [31:0]      t_val;
  logic signed [49:0]      seas;

  // derived configuration
  logic [5:0] w_eff;
  logic [5:0] span;
  logic [4:0] half;
  logic       even_m;
  logic [6:0] tdiv;
  logic [6:0] per;

  assign w_eff  = (window_length == 6'd0) ? 6'd1 : window_length;
  assign span   = w_eff[0] ? w_eff : w_eff + 6'd1;
  assign half   = span[5:1];
  assign even_m = !window_length[0] && (window_length != 6'd0);
  assign tdiv   = even_m ? {window_length, 1'b0} : {1'b0, span};
  assign per    = (season_period == 7'd0) ? 7'd1 :
                  (season_period > 7'(MAX_PERIOD)) ? 7'(MAX_PERIOD) : season_period;

  logic accept;
  assign accept    = start && !busy;
  assign busy      = state != ST_IDLE;
  assign cfg_ready = 1'b1;

  // memories
  logic                     s_we;
  logic [SAW-1:0]           s_waddr;
  logic [SAW-1:0]           s_raddr;
  logic [31:0]              s_rdata;
  logic                     t_we;
  logic [SAW-1:0]           t_waddr;
  logic [31:0]              t_wdata;
  logic [SAW-1:0]           t_raddr;
  logic [31:0]              t_rdata;
  logic                     p_we;
  logic [PSUMW+CNTW-1:0]    p_wdata;
  logic [PAW-1:0]           p_raddr;
  logic [PSUMW+CNTW-1:0]    p_rdata;

  asd_ram #(.WIDTH(32), .DEPTH(MAX_SAMPLES)) u_sample_ram (
    .clk(clk), .we(s_we), .waddr(s_waddr), .wdata(request.sample),
    .raddr(s_raddr), .rdata(s_rdata)
  );

  asd_ram #(.WIDTH(32), .DEPTH(MAX_SAMPLES)) u_trend_ram (
    .clk(clk), .we(t_we), .waddr(t_waddr), .wdata(t_wdata),
    .raddr(t_raddr), .rdata(t_rdata)
  );

  asd_ram #(.WIDTH(PSUMW+CNTW), .DEPTH(MAX_PERIOD)) u_phase_ram (
    .clk(clk), .we(p_we), .waddr(ph), .wdata(p_wdata),
    .raddr(p_raddr), .rdata(p_rdata)
  );

  asd_div_req_t div_req;
  asd_div_rsp_t div_rsp;

  asd_div u_div (.clk(clk), .rst(rst), .req(div_req), .rsp(div_rsp));

  logic signed [31:0] s_rdata_s;
  logic signed [31:0] t_rdata_s;
  assign s_rdata_s = s_rdata;
  assign t_rdata_s = t_rdata;

  // phase entry fields
  logic signed [PSUMW-1:0] p_sum;
  logic [CNTW-1:0]         p_cnt;
  logic signed [32:0]      diff;
  logic signed [PSUMW-1:0] new_sum;
  logic [CNTW-1:0]         new_cnt;
  logic                    first_pass;

  assign p_sum      = p_rdata[PSUMW+CNTW-1:CNTW];
  assign p_cnt      = p_rdata[CNTW-1:0];
  assign diff       = 33'(s_rdata_s) - 33'(t_rdata_s);
  assign first_pass = idx < CNTW'(per);
  assign new_sum    = first_pass ? PSUMW'(diff) : p_sum + PSUMW'(diff);
  assign new_cnt    = first_pass ? CNTW'(1) : p_cnt + 1'b1;
  assign p_wdata    = {new_sum, new_cnt};

  // window accumulation term: middle samples of an even window count twice
  logic signed [39:0] w_term;
  logic [39:0]        acc_mag;
  logic [PSUMW-1:0]   sum_mag;
  logic               dbl;

  assign dbl     = even_m && (idx != first) && (idx != last);
  assign w_term  = dbl ? (40'(s_rdata_s) <<< 1) : 40'(s_rdata_s);
  assign acc_mag = acc[39] ? 40'(-acc) : 40'(acc);
  assign sum_mag = p_sum[PSUMW-1] ? PSUMW'(-p_sum) : PSUMW'(p_sum);

  logic [31:0] quo_signed;
  assign quo_signed = neg ? 32'(-div_rsp.quo[31:0]) : div_rsp.quo[31:0];

  logic signed [50:0] rest_full;
  assign rest_full = 51'(s_val) - 51'(t_val) - 51'(seas);

  always_comb begin
    s_we    = 1'b0;
    s_waddr = count[SAW-1:0];
    s_raddr = idx[SAW-1:0];
    t_we    = 1'b0;
    t_waddr = idx[SAW-1:0];
    t_wdata = edge_val;
    t_raddr = idx[SAW-1:0];
    p_we    = 1'b0;
    p_raddr = ph;
    div_req = '0;
    case (state)
      ST_IDLE: begin
        if (accept && request.operation == OP_PUSH && count != CNTW'(MAX_SAMPLES)) begin
          s_we = 1'b1;
        end
        if (accept && request.operation == OP_READ && finalized &&
            CNTW'(request.position) < count) begin
          div_req.go  = 1'b1;
          div_req.num = DIVW'(request.position);
          div_req.den = DIVDW'(per);
        end
      end
      ST_WDIV: begin
        div_req.go  = 1'b1;
        div_req.num = DIVW'(acc_mag) + DIVW'(tdiv[6:1]);
        div_req.den = DIVDW'(tdiv);
      end
      ST_WWAIT: begin
        t_we    = div_rsp.done;
        t_waddr = SAW'(last - CNTW'(half));
        t_wdata = quo_signed;
      end
      ST_FRD1: begin
        t_raddr = SAW'(half);
      end
      ST_FLEAD: begin
        t_we = idx < CNTW'(half);
      end
      ST_FRD2: begin
        t_raddr = SAW'(count - CNTW'(half) - 1'b1);
      end
      ST_FTAIL: begin
        t_we = idx < count;
      end
      ST_PACC: begin
        p_we = 1'b1;
      end
      ST_RRD: begin
        s_raddr = pos;
        t_raddr = pos;
      end
      ST_RCAP: begin
        if (p_cnt != '0) begin
          div_req.go  = 1'b1;
          div_req.num = DIVW'(sum_mag) + DIVW'(p_cnt[CNTW-1:1]);
          div_req.den = p_cnt;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      window_length <= 6'd3;
      season_period <= 7'd4;
      count         <= '0;
      finalized     <= 1'b0;
      overflowed    <= 1'b0;
      strobe        <= 1'b0;
    end else begin
      strobe <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (accept) begin
            case (request.operation)
              OP_PUSH: begin
                if (count == CNTW'(MAX_SAMPLES)) begin
                  overflowed <= 1'b1;
                end else begin
                  count     <= count + 1'b1;
                  finalized <= 1'b0;
                  if (count + 1'b1 >= CNTW'(span)) begin
                    first <= count + 1'b1 - CNTW'(span);
                    idx   <= count + 1'b1 - CNTW'(span);
                    last  <= count;
                    acc   <= '0;
                    state <= ST_WRD;
                  end
                end
              end
              OP_FINALIZE: begin
                if (count >= CNTW'(span)) begin
                  state <= ST_FRD1;
                end
              end
              OP_READ: begin
                if (!finalized) begin
                  result <= '{trend: '0, season: '0, rest: '0, status: STAT_NOT_FIN};
                  strobe <= 1'b1;
                end else if (CNTW'(request.position) >= count) begin
                  result <= '{trend: '0, season: '0, rest: '0, status: STAT_RANGE};
                  strobe <= 1'b1;
                end else begin
                  pos   <= request.position;
                  state <= ST_RMOD;
                end
              end
              default: begin
              end
            endcase
          end
        end
        ST_WRD: begin
          state <= ST_WACC;
        end
        ST_WACC: begin
          acc <= acc + w_term;
          if (idx == last) begin
            state <= ST_WDIV;
          end else begin
            idx   <= idx + 1'b1;
            state <= ST_WRD;
          end
        end
        ST_WDIV: begin
          neg   <= acc[39];
          state <= ST_WWAIT;
        end
        ST_WWAIT: begin
          if (div_rsp.done) begin
            state <= ST_IDLE;
          end
        end
        ST_FRD1: begin
          state <= ST_FCAP1;
        end
        ST_FCAP1: begin
          edge_val <= t_rdata_s;
          idx      <= '0;
          state    <= ST_FLEAD;
        end
        ST_FLEAD: begin
          if (idx < CNTW'(half)) begin
            idx <= idx + 1'b1;
          end else begin
            state <= ST_FRD2;
          end
        end
        ST_FRD2: begin
          state <= ST_FCAP2;
        end
        ST_FCAP2: begin
          edge_val <= t_rdata_s;
          idx      <= count - CNTW'(half);
          state    <= ST_FTAIL;
        end
        ST_FTAIL: begin
          if (idx < count) begin
            idx <= idx + 1'b1;
          end else begin
            idx   <= '0;
            ph    <= '0;
            state <= ST_PRD;
          end
        end
        ST_PRD: begin
          state <= ST_PACC;
        end
        ST_PACC: begin
          // phase rolls over at the season period
          ph  <= (7'(ph) + 7'd1 == per) ? '0 : ph + 1'b1;
          idx <= idx + 1'b1;
          if (idx == count - 1'b1) begin
            finalized <= 1'b1;
            state     <= ST_IDLE;
          end else begin
            state <= ST_PRD;
          end
        end
        ST_RMOD: begin
          if (div_rsp.done) begin
            ph    <= div_rsp.rem[PAW-1:0];
            state <= ST_RRD;
          end
        end
        ST_RRD: begin
          state <= ST_RCAP;
        end
        ST_RCAP: begin
          s_val <= s_rdata_s;
          t_val <= t_rdata_s;
          neg   <= p_sum[PSUMW-1];
          if (p_cnt == '0) begin
            seas  <= '0;
            state <= ST_ROUT;
          end else begin
            state <= ST_RDIV;
          end
        end
        ST_RDIV: begin
          if (div_rsp.done) begin
            seas  <= neg ? 50'(-$signed({1'b0, div_rsp.quo})) :
                           50'($signed({1'b0, div_rsp.quo}));
            state <= ST_ROUT;
          end
        end
        ST_ROUT: begin
          result.trend  <= t_val;
          result.season <= sat32(51'(seas));
          result.rest   <= sat32(rest_full);
          result.status <= overflowed ? STAT_OK_DROP : STAT_OK;
          strobe        <= 1'b1;
          state         <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase

      if (cfg_valid && cfg_ready &&
          (cfg_index == REG_WINDOW || cfg_index == REG_PERIOD)) begin
        if (cfg_index == REG_WINDOW) begin
          window_length <= cfg_data[5:0];
        end else begin
          season_period <= cfg_data;
        end
        count      <= '0;
        finalized  <= 1'b0;
        overflowed <= 1'b0;
        state      <= ST_IDLE;
        strobe     <= 1'b0;
      end
    end
  end

endmodule

// ===== rtl/asd_ram.sv =====
// ----------------------------------------------------------------------------
// asd_ram
// Generic simple dual port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module asd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/asd_div.sv =====
// ----------------------------------------------------------------------------
// asd_div
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module asd_div
  import asd_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  asd_div_req_t req,
  output asd_div_rsp_t rsp
);

  logic             running;
  logic [DIVCW-1:0] steps;
  logic [DIVW-1:0]  quo;
  logic [DIVDW-1:0] rem;
  logic [DIVDW-1:0] den;
  logic             done;
  logic [DIVDW:0]   shifted;
  logic [DIVDW:0]   diff;
  logic             ge;

  assign shifted = {rem, quo[DIVW-1]};
  assign diff    = shifted - {1'b0, den};
  assign ge      = shifted >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.go) begin
        quo     <= req.num;
        rem     <= '0;
        den     <= req.den;
        steps   <= DIVCW'(DIV_STEPS);
        running <= 1'b1;
      end else if (running) begin
        rem   <= ge ? diff[DIVDW-1:0] : shifted[DIVDW-1:0];
        quo   <= {quo[DIVW-2:0], ge};
        steps <= steps - 1'b1;
        if (steps == DIVCW'(1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done;
  assign rsp.quo  = quo;
  assign rsp.rem  = rem;

endmodule

// ===== rtl/asd_checker.sv =====
// ----------------------------------------------------------------------------
// asd_checker
// Port level checks of the decomposition block, bound to the top level.
// ----------------------------------------------------------------------------
module asd_checker
  import asd_pkg::*;
(
  input logic     clk,
  input logic     rst,
  input logic     start,
  input logic     busy,
  input asd_req_t request,
  input logic     strobe,
  input asd_res_t result
);

  // a result only follows a read request or ongoing work
  a_strobe_cause: assert property (@(posedge clk) disable iff (rst)
    strobe |-> $past(busy) || $past(start && request.operation == OP_READ))
    else $error("result without a read request");

  // push and finalize never answer
  a_no_answer: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (request.operation == OP_PUSH ||
     request.operation == OP_FINALIZE)) |=> !strobe)
    else $error("result after push or finalize");

  // refused reads carry zero components
  a_refused_zero: assert property (@(posedge clk) disable iff (rst)
    (strobe && (result.status == STAT_RANGE || result.status == STAT_NOT_FIN)) |->
    (result.trend == 0 && result.season == 0 && result.rest == 0))
    else $error("refused read with nonzero fields");

  // no result right after reset
  a_reset_quiet: assert property (@(posedge clk)
    $past(rst) |-> !strobe)
    else $error("result right after reset");

endmodule

bind additive_seasonal_decomposition_top asd_checker u_asd_checker (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .request(request),
  .strobe(strobe), .result(result)
);

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Checks the additive seasonal decomposition block against a built-in
// predictor. It drives pushes, finalizes and reads under several window and
// period settings, the extremes among them.
// Every read result is compared field by field with the predicted one.
// ----------------------------------------------------------------------------
module tb_top;
  import asd_pkg::*;

  class decomp_scoreboard;
    logic signed [31:0] samples [MAX_SAMPLES];
    logic signed [31:0] trends [MAX_SAMPLES];
    longint             phase_sum [MAX_PERIOD];
    int                 phase_cnt [MAX_PERIOD];
    int                 stored;
    bit                 done_fin;
    bit                 dropped;
    int unsigned        win_len;
    int unsigned        per_len;
    asd_res_t           expected_reads [$];
    int                 mismatches;

    function new();
      win_len = 3;
      per_len = 4;
      mismatches = 0;
      clear();
    endfunction

    function void clear();
      foreach (phase_sum[i]) begin
        phase_sum[i] = 0;
        phase_cnt[i] = 0;
      end
      stored = 0;
      done_fin = 0;
      dropped = 0;
    endfunction

    function void set_register(logic [1:0] idx, logic [6:0] val);
      if (idx == REG_WINDOW) begin
        win_len = 32'(val & 7'h3f);
        clear();
      end else if (idx == REG_PERIOD) begin
        per_len = 32'(val);
        clear();
      end
    endfunction

    function int unsigned span();
      int unsigned w;
      w = (win_len == 0) ? 1 : win_len;
      if (w > 63) w = 63;
      return (w % 2 == 1) ? w : w + 1;
    endfunction

    function int unsigned period();
      int unsigned p;
      p = (per_len == 0) ? 1 : per_len;
      return (p > MAX_PERIOD) ? MAX_PERIOD : p;
    endfunction

    function longint div_nearest(longint num, longint den);
      longint mag;
      longint q;
      mag = (num < 0) ? -num : num;
      q = (mag + den / 2) / den;
      return (num < 0) ? -q : q;
    endfunction

    function logic signed [31:0] clip32(longint v);
      if (v > 64'sd2147483647) return 32'sh7fffffff;
      if (v < -64'sd2147483648) return 32'sh80000000;
      return v[31:0];
    endfunction

    function void push_sample(logic signed [31:0] x);
      int unsigned sp;
      int unsigned t;
      int unsigned first;
      longint acc;
      if (stored >= MAX_SAMPLES) begin
        dropped = 1;
        return;
      end
      t = stored;
      samples[t] = x;
      stored = t + 1;
      done_fin = 0;
      sp = span();
      if (stored < sp) return;
      first = t + 1 - sp;
      acc = 0;
      if (win_len % 2 == 0 && win_len != 0 && sp > 1) begin
        // 2xm average: end samples once, inner ones twice
        acc = longint'(samples[first]) + longint'(samples[t]);
        for (int unsigned i = first + 1; i < t; i++) acc += 2 * longint'(samples[i]);
        trends[t - sp / 2] = 32'(div_nearest(acc, 2 * (sp - 1)));
      end else begin
        for (int unsigned i = first; i <= t; i++) acc += longint'(samples[i]);
        trends[t - sp / 2] = 32'(div_nearest(acc, sp));
      end
    endfunction

    function void finalize();
      int unsigned sp;
      int unsigned half;
      int unsigned ph;
      sp = span();
      half = sp / 2;
      if (stored < sp) return;
      for (int unsigned i = 0; i < half; i++) trends[i] = trends[half];
      for (int unsigned i = stored - half; i < stored; i++)
        trends[i] = trends[stored - half - 1];
      foreach (phase_sum[i]) begin
        phase_sum[i] = 0;
        phase_cnt[i] = 0;
      end
      for (int unsigned i = 0; i < stored; i++) begin
        ph = i % period();
        phase_sum[ph] += longint'(samples[i]) - longint'(trends[i]);
        phase_cnt[ph]++;
      end
      done_fin = 1;
    endfunction

    function void note_request(asd_req_t r);
      asd_res_t e;
      longint seas;
      int unsigned ph;
      case (r.operation)
        OP_PUSH: push_sample(r.sample);
        OP_FINALIZE: finalize();
        OP_READ: begin
          e = '0;
          if (!done_fin) begin
            e.status = STAT_NOT_FIN;
          end else if (r.position >= stored) begin
            e.status = STAT_RANGE;
          end else begin
            ph = r.position % period();
            seas = 0;
            if (phase_cnt[ph] != 0) seas = div_nearest(phase_sum[ph], phase_cnt[ph]);
            e.trend = trends[r.position];
            e.season = clip32(seas);
            e.rest = clip32(longint'(samples[r.position]) - longint'(trends[r.position])
                            - seas);
            e.status = dropped ? STAT_OK_DROP : STAT_OK;
          end
          expected_reads.push_back(e);
        end
        default: ;
      endcase
    endfunction

    function void check_result(asd_res_t got);
      asd_res_t e;
      if (expected_reads.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", got);
        return;
      end
      e = expected_reads.pop_front();
      if (got.trend !== e.trend || got.season !== e.season || got.rest !== e.rest ||
          got.status !== e.status) begin
        mismatches++;
        if (mismatches <= 10) $display("mismatch: expected %p got %p", e, got);
      end
    endfunction

    function int pending();
      return expected_reads.size();
    endfunction
  endclass

  localparam int QUIET_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 2500;

  logic       clk;
  logic       rst;
  logic       start;
  logic       busy;
  asd_req_t   req;
  logic       strobe;
  asd_res_t   res;
  logic       cfg_valid;
  logic       cfg_ready;
  logic [1:0] cfg_index;
  logic [6:0] cfg_data;

  decomp_scoreboard sb;
  int quiet;
  int sent;
  int idle_pct;

  additive_seasonal_decomposition_top uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .request(req),
    .strobe(strobe), .result(res), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  // signals change only at rising edges, so mid-cycle values are the ones
  // seen by the next edge
  always @(negedge clk) begin
    if (!rst) begin
      if (strobe) begin
        sb.check_result(res);
      end
      if (start && !busy) begin
        sb.note_request(req);
      end
      if (strobe || (start && !busy) || (cfg_valid && cfg_ready)) begin
        quiet <= 0;
      end else begin
        quiet <= quiet + 1;
      end
      if (quiet >= QUIET_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  task automatic send(logic [1:0] op, logic signed [31:0] x, logic [9:0] pos);
    asd_req_t r;
    r.operation = op;
    r.sample = x;
    r.position = pos;
    start <= 1'b1;
    req <= r;
    do @(negedge clk); while (busy);
    @(posedge clk);
    sent++;
    idle_pct = (sent < 250) ? 19 : (sent < 500) ? 71 : 0;
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [6:0] val);
    drain();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(negedge clk); while (!cfg_ready);
    sb.set_register(idx, val);
    @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic signed [31:0] rand_sample();
    case ($urandom_range(7))
      0: return $urandom;
      1: return 32'sh7fffffff;
      2: return 32'sh80000000;
      default: return $signed($urandom_range(2 * (1 << 22))) - (1 << 22);
    endcase
  endfunction

  task automatic run_set(int w, int p, int n, int reads);
    write_reg(REG_WINDOW, 7'(w));
    write_reg(REG_PERIOD, 7'(p));
    send(OP_READ, 0, 10'($urandom));
    for (int i = 0; i < n; i++) begin
      send(OP_PUSH, rand_sample(), 10'($urandom));
      if ($urandom_range(19) == 0) send(OP_UNUSED, $urandom, 10'($urandom));
    end
    send(OP_FINALIZE, $urandom, 10'($urandom));
    for (int i = 0; i < reads; i++) begin
      if ($urandom_range(9) == 0) send(OP_READ, $urandom, 10'($urandom));
      else send(OP_READ, $urandom, 10'($urandom_range(n > 0 ? n - 1 : 0)));
    end
    // push after finalize needs a fresh finalize
    send(OP_PUSH, rand_sample(), 10'($urandom));
    send(OP_READ, $urandom, 0);
    send(OP_FINALIZE, $urandom, 10'($urandom));
    for (int i = 0; i < 4; i++) send(OP_READ, $urandom, 10'($urandom_range(n)));
  endtask

  initial begin
    sb = new();
    rst = 1'b1;
    start = 1'b0;
    req = '0;
    cfg_valid = 1'b0;
    cfg_index = REG_WINDOW;
    cfg_data = '0;
    quiet = 0;
    sent = 0;
    idle_pct = 19;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: reset settings, refused reads, too few samples, extremes
    send(OP_READ, 0, 0);
    send(OP_PUSH, 32'sh7fffffff, 0);
    send(OP_PUSH, 32'sh7fffffff, 0);
    send(OP_FINALIZE, 0, 0);
    send(OP_READ, 0, 0);
    send(OP_PUSH, 32'sh80000000, 0);
    send(OP_PUSH, 32'sh80000000, 10'h3ff);
    send(OP_PUSH, 32'sh7fffffff, 0);
    send(OP_PUSH, 32'sh00000000, 0);
    send(OP_PUSH, 32'shffffffff, 0);
    send(OP_UNUSED, 32'sh12345678, 10'h155);
    send(OP_FINALIZE, 0, 0);
    for (int i = 0; i < 7; i++) send(OP_READ, 0, 10'(i));
    send(OP_READ, 0, 10'h3ff);
    send(OP_UNUSED, 0, 0);

    run_set(0, 0, 12, 8);
    run_set(1, 1, 20, 10);
    run_set(2, 64, 30, 12);
    run_set(63, 127, 70, 15);
    run_set(62, 5, 65, 12);
    run_set(4, 7, 40, 14);
    run_set(63, 2, 30, 6);
    for (int k = 0; k < 7; k++)
      run_set($urandom_range(1, 12), $urandom_range(1, 70), $urandom_range(5, 40), 12);

    drain();
    if (sb.mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== additive_seasonal_decomposition_top.f =====
rtl/asd_pkg.sv
rtl/asd_ram.sv
rtl/asd_div.sv
rtl/additive_seasonal_decomposition_top.sv
rtl/asd_checker.sv
tb/sv/tb_top.sv
